// ===== rtl/seven_segment_display_command_encoder_core_macros.svh =====
// Assertion macros shared by the encoder modules.
// Expects signals clk and rst_n in the including scope; no other dependencies.
`ifndef SEVEN_SEGMENT_DISPLAY_COMMAND_ENCODER_CORE_MACROS_SVH
`define SEVEN_SEGMENT_DISPLAY_COMMAND_ENCODER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SSDCE_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SSDCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SSDCE_ASSERT_IMPLY(lbl, ante, cons, msg)
`define SSDCE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/ssdce_pkg.sv =====
// Shared types, constants and font table for the seven-segment command encoder.
// No dependencies.
package ssdce_pkg;

  localparam int DIGIT_COUNT_DEF = 4;
  localparam int MAX_DIGITS      = 8;
  localparam int DIG_W           = 3;   // digit index wide enough for MAX_DIGITS
  localparam int NUM_W           = 16;
  localparam int NUM_STEPS       = 4;   // decimal digits shown by show-number

  localparam logic [6:0]  DISP_BASE   = 7'h34;
  localparam logic [6:0]  CTRL_BASE   = 7'h24;
  localparam logic [3:0]  BRT_MAX     = 4'd7;
  localparam logic [2:0]  INIT_BRT    = 3'd3;
  localparam logic [7:0]  ASCII_ZERO  = 8'h30;
  localparam logic [7:0]  ASCII_SPACE = 8'h20;
  // n / 10 == (n * 0xCCCD) >> 19 for every 16-bit n
  localparam logic [16:0] RECIP_TEN   = 17'h0CCCD;
  localparam int          RECIP_SHIFT = 19;

  typedef enum logic [2:0] {
    OP_CHAR   = 3'd0,
    OP_DOT    = 3'd1,
    OP_BRIGHT = 3'd2,
    OP_ONOFF  = 3'd3,
    OP_NUMBER = 3'd4,
    OP_CLEAR  = 3'd5,
    OP_INIT   = 3'd6
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEG,
    ST_ON,
    ST_BRT,
    ST_NUM
  } state_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_SEG_CHAR,
    DP_SEG_DOT,
    DP_SEG_ZERO,
    DP_ON_CMD,
    DP_ON_SET,
    DP_BRT_CMD,
    DP_BRT_INIT,
    DP_NUM,
    DP_NUM_SKIP
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [DIG_W-1:0] digit;
    logic             last;
    logic             first;   // first show-number step: ones digit never blanked
  } dp_cmd_t;

  typedef struct packed {
    logic room;   // output register can take a beat this cycle
  } dp_sts_t;

  function automatic logic [7:0] font_seg(input logic [6:0] c);
    logic [7:0] s;
    case (c)
      7'h21: s = 8'h82;  7'h22: s = 8'h21;  7'h27: s = 8'h02;  7'h28: s = 8'h39;
      7'h29: s = 8'h0F;  7'h2D: s = 8'h40;  7'h2E: s = 8'h80;
      7'h30: s = 8'h3F;  7'h31: s = 8'h06;  7'h32: s = 8'h5B;  7'h33: s = 8'h4F;
      7'h34: s = 8'h66;  7'h35: s = 8'h6D;  7'h36: s = 8'h7D;  7'h37: s = 8'h07;
      7'h38: s = 8'h7F;  7'h39: s = 8'h6F;  7'h3D: s = 8'h48;  7'h3F: s = 8'h53;
      7'h41: s = 8'h77;  7'h42: s = 8'h7C;  7'h43: s = 8'h39;  7'h44: s = 8'h5E;
      7'h45: s = 8'h79;  7'h46: s = 8'h71;  7'h47: s = 8'h6F;  7'h48: s = 8'h76;
      7'h49: s = 8'h06;  7'h4A: s = 8'h1E;  7'h4C: s = 8'h38;  7'h4E: s = 8'h54;
      7'h4F: s = 8'h3F;
      7'h50: s = 8'h73;  7'h51: s = 8'h67;  7'h52: s = 8'h50;  7'h53: s = 8'h6D;
      7'h54: s = 8'h78;  7'h55: s = 8'h3E;  7'h59: s = 8'h6E;  7'h5B: s = 8'h39;
      7'h5D: s = 8'h0F;  7'h5F: s = 8'h08;
      7'h60: s = 8'h63;  7'h61: s = 8'h5F;  7'h62: s = 8'h7C;  7'h63: s = 8'h58;
      7'h64: s = 8'h5E;  7'h65: s = 8'h7B;  7'h66: s = 8'h71;  7'h67: s = 8'h6F;
      7'h68: s = 8'h74;  7'h69: s = 8'h02;  7'h6A: s = 8'h1E;  7'h6C: s = 8'h06;
      7'h6E: s = 8'h54;  7'h6F: s = 8'h5C;
      7'h70: s = 8'h73;  7'h71: s = 8'h67;  7'h72: s = 8'h50;  7'h73: s = 8'h6D;
      7'h74: s = 8'h78;  7'h75: s = 8'h1C;  7'h79: s = 8'h6E;  7'h7B: s = 8'h39;
      7'h7C: s = 8'h30;  7'h7D: s = 8'h0F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/ssdce_ctrl.sv =====
// Command sequencer FSM: validates commands and steps through their writes.
// Depends on ssdce_pkg and the assertion macro header.
`include "seven_segment_display_command_encoder_core_macros.svh"

module ssdce_ctrl #(
  parameter int DIGIT_COUNT = ssdce_pkg::DIGIT_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_opcode,
  input  logic [2:0]         in_position,
  input  logic [3:0]         in_level,
  input  ssdce_pkg::dp_sts_t sts,
  output ssdce_pkg::dp_cmd_t cmd
);

  localparam int           DW     = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [3:0]   DC4    = 4'(DIGIT_COUNT);
  localparam logic [DW-1:0] LAST_D = DW'(DIGIT_COUNT - 1);

  ssdce_pkg::state_t  state_r, state_nxt;
  ssdce_pkg::opcode_t op_r, op_nxt;
  logic [DW-1:0]      d_r, d_nxt;
  logic [DW-1:0]      hi_r, hi_nxt;
  logic [1:0]         i_r, i_nxt;

  ssdce_pkg::opcode_t in_op;
  logic               span_ok, pos_all, at_end, is_init, num_skip;
  logic [DW-1:0]      span_hi;
  logic [1:0]         num_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssdce_pkg::ST_IDLE;
      op_r    <= ssdce_pkg::OP_CHAR;
      d_r     <= '0;
      hi_r    <= '0;
      i_r     <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      d_r     <= d_nxt;
      hi_r    <= hi_nxt;
      i_r     <= i_nxt;
    end
  end

  always_comb begin
    in_op     = ssdce_pkg::opcode_t'(in_opcode);
    span_ok   = ({1'b0, in_position} <= DC4);
    pos_all   = (in_position == 3'd0);
    span_hi   = pos_all ? LAST_D : DW'(in_position - 3'd1);
    at_end    = (d_r == hi_r);
    is_init   = (op_r == ssdce_pkg::OP_INIT);
    num_d     = 2'd3 - i_r;
    num_skip  = ({2'b00, num_d} >= DC4);

    state_nxt = state_r;
    op_nxt    = op_r;
    d_nxt     = d_r;
    hi_nxt    = hi_r;
    i_nxt     = i_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.op    = ssdce_pkg::DP_NONE;

    unique case (state_r)
      ssdce_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = ssdce_pkg::DP_LOAD;
          op_nxt = in_op;
          unique case (in_op) inside
            ssdce_pkg::OP_CHAR: begin
              if ({1'b0, in_position} < DC4) begin
                d_nxt     = DW'(in_position);
                hi_nxt    = DW'(in_position);
                state_nxt = ssdce_pkg::ST_SEG;
              end
            end
            ssdce_pkg::OP_DOT, ssdce_pkg::OP_ONOFF: begin
              if (span_ok) begin
                d_nxt     = pos_all ? '0 : span_hi;
                hi_nxt    = span_hi;
                state_nxt = (in_op == ssdce_pkg::OP_DOT) ? ssdce_pkg::ST_SEG
                                                         : ssdce_pkg::ST_ON;
              end
            end
            ssdce_pkg::OP_BRIGHT: begin
              if (span_ok && (in_level <= ssdce_pkg::BRT_MAX)) begin
                d_nxt     = pos_all ? '0 : span_hi;
                hi_nxt    = span_hi;
                state_nxt = ssdce_pkg::ST_BRT;
              end
            end
            ssdce_pkg::OP_NUMBER: begin
              i_nxt     = '0;
              state_nxt = ssdce_pkg::ST_NUM;
            end
            ssdce_pkg::OP_CLEAR, ssdce_pkg::OP_INIT: begin
              d_nxt     = '0;
              hi_nxt    = LAST_D;
              state_nxt = ssdce_pkg::ST_SEG;
            end
            default: begin
              // unused opcode: dropped
            end
          endcase
        end
      end

      ssdce_pkg::ST_SEG: begin
        if (sts.room) begin
          unique case (op_r) inside
            ssdce_pkg::OP_CHAR: cmd.op = ssdce_pkg::DP_SEG_CHAR;
            ssdce_pkg::OP_DOT:  cmd.op = ssdce_pkg::DP_SEG_DOT;
            default:            cmd.op = ssdce_pkg::DP_SEG_ZERO;
          endcase
          cmd.digit = ssdce_pkg::DIG_W'(d_r);
          cmd.last  = at_end && !is_init;
          if (at_end) begin
            if (is_init) begin
              d_nxt     = '0;
              hi_nxt    = LAST_D;
              state_nxt = ssdce_pkg::ST_ON;
            end else begin
              state_nxt = ssdce_pkg::ST_IDLE;
            end
          end else begin
            d_nxt = d_r + 1'b1;
          end
        end
      end

      ssdce_pkg::ST_ON: begin
        if (sts.room) begin
          cmd.op    = is_init ? ssdce_pkg::DP_ON_SET : ssdce_pkg::DP_ON_CMD;
          cmd.digit = ssdce_pkg::DIG_W'(d_r);
          cmd.last  = at_end && !is_init;
          if (at_end) begin
            if (is_init) begin
              d_nxt     = '0;
              hi_nxt    = LAST_D;
              state_nxt = ssdce_pkg::ST_BRT;
            end else begin
              state_nxt = ssdce_pkg::ST_IDLE;
            end
          end else begin
            d_nxt = d_r + 1'b1;
          end
        end
      end

      ssdce_pkg::ST_BRT: begin
        if (sts.room) begin
          cmd.op    = is_init ? ssdce_pkg::DP_BRT_INIT : ssdce_pkg::DP_BRT_CMD;
          cmd.digit = ssdce_pkg::DIG_W'(d_r);
          cmd.last  = at_end;
          if (at_end) begin
            state_nxt = ssdce_pkg::ST_IDLE;
          end else begin
            d_nxt = d_r + 1'b1;
          end
        end
      end

      ssdce_pkg::ST_NUM: begin
        // digits beyond the display still take a divide step
        if (num_skip || sts.room) begin
          cmd.op    = num_skip ? ssdce_pkg::DP_NUM_SKIP : ssdce_pkg::DP_NUM;
          cmd.digit = ssdce_pkg::DIG_W'(num_d);
          cmd.last  = (i_r == 2'd3);
          cmd.first = (i_r == 2'd0);
          if (i_r == 2'd3) begin
            state_nxt = ssdce_pkg::ST_IDLE;
          end else begin
            i_nxt = i_r + 2'd1;
          end
        end
      end

      default: state_nxt = ssdce_pkg::ST_IDLE;
    endcase
  end

  `SSDCE_ASSERT_NEXT(a_last_ends_cmd, cmd.last, state_r == ssdce_pkg::ST_IDLE, "run past last")
  `SSDCE_ASSERT_IMPLY(a_digit_in_span, state_r != ssdce_pkg::ST_IDLE, d_r <= hi_r, "past span")

endmodule

// ===== rtl/ssdce_dp.sv =====
// Datapath: digit shadows, decimal split for show-number, output register.
// Depends on ssdce_pkg and the assertion macro header.
`include "seven_segment_display_command_encoder_core_macros.svh"

module ssdce_dp #(
  parameter int DIGIT_COUNT = ssdce_pkg::DIGIT_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_char_code,
  input  logic [3:0]         in_level,
  input  logic               in_flag,
  input  logic [15:0]        in_number,
  input  ssdce_pkg::dp_cmd_t cmd,
  output ssdce_pkg::dp_sts_t sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [6:0]         out_bus_address,
  output logic [7:0]         out_data_byte,
  output logic               out_last
);

  localparam int DW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  logic [7:0]  seg_r [DIGIT_COUNT];
  logic [3:0]  ctl_r [DIGIT_COUNT];   // {brightness, on}
  logic [6:0]  char_r;
  logic        flag_r;
  logic [2:0]  level_r;
  logic [15:0] num_r;

  logic        out_valid_r;
  logic [6:0]  out_addr_r;
  logic [7:0]  out_data_r;
  logic        out_last_r;

  logic [DW-1:0] dsel;
  logic [7:0]    seg_cur, seg_new;
  logic [3:0]    ctl_cur, ctl_new;
  logic [32:0]   prod;
  logic [15:0]   quo, ten_q, rem_full;
  logic [7:0]    num_ch;
  logic [7:0]    glyph_chr, glyph_num;
  logic          emit_seg, emit_ctl, emit, num_step;
  logic [6:0]    addr_new;
  logic [7:0]    data_new;

  always_comb begin
    dsel     = cmd.digit[DW-1:0];
    seg_cur  = seg_r[dsel];
    ctl_cur  = ctl_r[dsel];

    prod     = num_r * ssdce_pkg::RECIP_TEN;
    quo      = 16'(prod >> ssdce_pkg::RECIP_SHIFT);
    ten_q    = (quo << 3) + (quo << 1);
    rem_full = num_r - ten_q;
    num_ch   = ((num_r != 16'd0) || cmd.first) ? (ssdce_pkg::ASCII_ZERO + {4'b0, rem_full[3:0]})
                                               : ssdce_pkg::ASCII_SPACE;
    glyph_chr = ssdce_pkg::font_seg(char_r);
    glyph_num = ssdce_pkg::font_seg(num_ch[6:0]);

    seg_new  = seg_cur;
    ctl_new  = ctl_cur;
    emit_seg = 1'b0;
    emit_ctl = 1'b0;
    num_step = 1'b0;
    unique case (cmd.op)
      ssdce_pkg::DP_SEG_CHAR: begin
        emit_seg = 1'b1;
        seg_new  = {seg_cur[7], glyph_chr[6:0]};
      end
      ssdce_pkg::DP_SEG_DOT: begin
        emit_seg = 1'b1;
        seg_new  = {flag_r, seg_cur[6:0]};
      end
      ssdce_pkg::DP_SEG_ZERO: begin
        emit_seg = 1'b1;
        seg_new  = 8'h00;
      end
      ssdce_pkg::DP_NUM: begin
        emit_seg = 1'b1;
        num_step = 1'b1;
        seg_new  = {seg_cur[7], glyph_num[6:0]};
      end
      ssdce_pkg::DP_NUM_SKIP: num_step = 1'b1;
      ssdce_pkg::DP_ON_CMD: begin
        emit_ctl = 1'b1;
        ctl_new  = {ctl_cur[3:1], flag_r};
      end
      ssdce_pkg::DP_ON_SET: begin
        emit_ctl = 1'b1;
        ctl_new  = {ctl_cur[3:1], 1'b1};
      end
      ssdce_pkg::DP_BRT_CMD: begin
        emit_ctl = 1'b1;
        ctl_new  = {level_r, ctl_cur[0]};
      end
      ssdce_pkg::DP_BRT_INIT: begin
        emit_ctl = 1'b1;
        ctl_new  = {ssdce_pkg::INIT_BRT, ctl_cur[0]};
      end
      default: begin
        // idle or load
      end
    endcase

    emit     = emit_seg || emit_ctl;
    addr_new = (emit_seg ? ssdce_pkg::DISP_BASE : ssdce_pkg::CTRL_BASE)
               + {4'b0, cmd.digit};
    data_new = emit_seg ? seg_new : {1'b0, ctl_new[3:1], 3'b000, ctl_new[0]};
  end

  assign sts.room = !out_valid_r || out_ready;

  // shadows and handshake state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        seg_r[i] <= 8'h00;
        ctl_r[i] <= 4'h0;
      end
    end else begin
      if (emit_seg) seg_r[dsel] <= seg_new;
      if (emit_ctl) ctl_r[dsel] <= ctl_new;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.op == ssdce_pkg::DP_LOAD) begin
      char_r  <= in_char_code[6:0];
      flag_r  <= in_flag;
      level_r <= in_level[2:0];
      num_r   <= in_number;
    end else if (num_step) begin
      num_r   <= quo;
    end
    if (emit) begin
      out_addr_r <= addr_new;
      out_data_r <= data_new;
      out_last_r <= cmd.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bus_address = out_addr_r;
  assign out_data_byte   = out_data_r;
  assign out_last        = out_last_r;

  `SSDCE_ASSERT_IMPLY(a_emit_has_room, emit, sts.room, "write issued while output register full")
  `SSDCE_ASSERT_NEXT(a_emit_shows, emit, out_valid_r, "issued write not presented on output")

endmodule

// ===== rtl/seven_segment_display_command_encoder_core.sv =====
// Top level of the seven-segment display command encoder.
// Depends on ssdce_pkg, ssdce_ctrl and ssdce_dp.
//  - Input channel (in_valid/in_ready): one display command per beat, fields
//    in_opcode, in_position, in_char_code, in_level, in_flag, in_number.
//  - Output channel (out_valid/out_ready): one bus register write per beat,
//    out_bus_address / out_data_byte, out_last marks the final write of a
//    command. Rejected commands (bad position, brightness over 7, unused
//    opcode) produce no beats.
//  - in_ready is high only while the sequencer is idle; one command is
//    worked at a time. After the accept state the sequencer takes one step
//    per write while the output register has room (show-number: a step for
//    each of four digits, skipped digits included; init: 3*DIGIT_COUNT
//    writes). Each write is registered before it appears on the output.
//  - The output register decouples the channels: the next command is taken
//    while the final write still waits. When the receiver stalls, the
//    sequencer holds on its current write, one per cycle at best.
//  - Reset (rst_n low, synchronous) clears all segment and control shadows
//    and the output valid; no clearing pass is needed.
//  - Throughput (single output register): one write per cycle if unstalled.

module seven_segment_display_command_encoder_core #(
  parameter int DIGIT_COUNT = ssdce_pkg::DIGIT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [2:0]  in_position,
  input  logic [7:0]  in_char_code,
  input  logic [3:0]  in_level,
  input  logic        in_flag,
  input  logic [15:0] in_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_bus_address,
  output logic [7:0]  out_data_byte,
  output logic        out_last
);

  ssdce_pkg::dp_cmd_t cmd;   // sequencer -> datapath
  ssdce_pkg::dp_sts_t sts;   // datapath -> sequencer

  // FSM: validation, digit spans, write ordering
  ssdce_ctrl #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_position (in_position),
    .in_level    (in_level),
    .sts         (sts),
    .cmd         (cmd)
  );

  // shadows, font lookup, divide-by-ten step, output register
  ssdce_dp #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_char_code    (in_char_code),
    .in_level        (in_level),
    .in_flag         (in_flag),
    .in_number       (in_number),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_bus_address (out_bus_address),
    .out_data_byte   (out_data_byte),
    .out_last        (out_last)
  );

endmodule
